### rtl/core/key_expiry_heap_table_unit_macros.svh
// assertion macros for the expiry table checker
`ifndef KEY_EXPIRY_HEAP_TABLE_UNIT_MACROS_SVH
`define KEY_EXPIRY_HEAP_TABLE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define KEHT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keht check failed");

// next-cycle implication, sampled on clk, off during reset
`define KEHT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keht check failed");

`endif

### rtl/core/keht_pkg.sv
// ----------------------------------------------------------------------------
// keht_pkg
// shared codes and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package keht_pkg;

  localparam logic [2:0] MODE_ADD    = 3'd0;
  localparam logic [2:0] MODE_REMOVE = 3'd1;
  localparam logic [2:0] MODE_CHECK  = 3'd2;
  localparam logic [2:0] MODE_LOOKUP = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;
  localparam logic [2:0] MODE_SWEEP  = 3'd5;

  localparam logic [7:0] BATCH_RESET = 8'd100;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_IDLE    = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD    = 4'd1;
  localparam logic [OP_W-1:0] OP_EVAL    = 4'd2;
  localparam logic [OP_W-1:0] OP_UP_RD   = 4'd3;
  localparam logic [OP_W-1:0] OP_UP_MOVE = 4'd4;
  localparam logic [OP_W-1:0] OP_UP_FIN  = 4'd5;
  localparam logic [OP_W-1:0] OP_DN_LAST = 4'd6;
  localparam logic [OP_W-1:0] OP_DN_LD   = 4'd7;
  localparam logic [OP_W-1:0] OP_DN_RD   = 4'd8;
  localparam logic [OP_W-1:0] OP_DN_CMP  = 4'd9;
  localparam logic [OP_W-1:0] OP_SW_RD   = 4'd10;
  localparam logic [OP_W-1:0] OP_SW_ENT  = 4'd11;
  localparam logic [OP_W-1:0] OP_SW_KILL = 4'd12;
  localparam logic [OP_W-1:0] OP_CLR     = 4'd13;
  localparam logic [OP_W-1:0] OP_DONE    = 4'd14;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       push;
    logic       hole_zero;
    logic       item_lt_a;
    logic       dn_move;
    logic       stale;
    logic       due;
    logic       sweep_stop;
    logic       clr_last;
  } status_t;

endpackage

`default_nettype wire

### rtl/core/key_expiry_heap_table_unit.sv
// ----------------------------------------------------------------------------
// key_expiry_heap_table_unit
// expiry table with a lazy-deletion min-heap of (key, deadline) pairs
// ----------------------------------------------------------------------------
// One command is in flight at a time: it is taken when start is high and busy
// is low, and its result appears on the out_ ports for one cycle with out_valid
// high; the receiver cannot stall, so it must take every result as it comes.
// Remove, check, lookup, unused modes and an add that does not push go through
// entry memory read, evaluate and result. An add that pushes then climbs the
// heap a level at a time (read parent, compare, move) until it reaches the
// root or a parent that is not larger. A sweep reads the heap top and its
// entry and ends at an entry not yet due, an empty heap or its batch limit;
// each stale or due top is popped: the last item is loaded and sifted down a
// level at a time (read children, compare, write). Clear walks the entry
// memory one key a cycle. After reset the same clearing pass runs with busy
// high; configuration writes are taken throughout.
`default_nettype none

module key_expiry_heap_table_unit import keht_pkg::*; #(
  parameter int KEY_BITS   = 12,
  parameter int HEAP_DEPTH = 4096,
  parameter int TIME_BITS  = 48
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [2:0]           in_mode,
  input  wire logic [KEY_BITS-1:0]  in_key,
  input  wire logic [TIME_BITS-1:0] in_deadline,
  input  wire logic [TIME_BITS-1:0] in_now,
  output logic                      out_valid,
  output logic                      out_hit,
  output logic                      out_was_expired,
  output logic [TIME_BITS-1:0]      out_deadline_out,
  output logic [7:0]                out_swept_count,
  output logic                      out_heap_full,
  input  wire logic                 cfg_wr_en,
  input  wire logic [7:0]           cfg_wr_data
);

  cmd_t    cmd;
  status_t status;

  keht_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  keht_datapath #(
    .KEY_BITS   (KEY_BITS),
    .HEAP_DEPTH (HEAP_DEPTH),
    .TIME_BITS  (TIME_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_mode          (in_mode),
    .in_key           (in_key),
    .in_deadline      (in_deadline),
    .in_now           (in_now),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_was_expired  (out_was_expired),
    .out_deadline_out (out_deadline_out),
    .out_swept_count  (out_swept_count),
    .out_heap_full    (out_heap_full)
  );

endmodule

`default_nettype wire

### rtl/core/keht_datapath.sv
// ----------------------------------------------------------------------------
// keht_datapath
// entry and heap memories, moving item, counters and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module keht_datapath import keht_pkg::*; #(
  parameter int KEY_BITS   = 12,
  parameter int HEAP_DEPTH = 4096,
  parameter int TIME_BITS  = 48
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cmd_t                 cmd,
  output status_t                   status,
  input  wire logic [2:0]           in_mode,
  input  wire logic [KEY_BITS-1:0]  in_key,
  input  wire logic [TIME_BITS-1:0] in_deadline,
  input  wire logic [TIME_BITS-1:0] in_now,
  input  wire logic                 cfg_wr_en,
  input  wire logic [7:0]           cfg_wr_data,
  output logic                      out_valid,
  output logic                      out_hit,
  output logic                      out_was_expired,
  output logic [TIME_BITS-1:0]      out_deadline_out,
  output logic [7:0]                out_swept_count,
  output logic                      out_heap_full
);

  localparam int KEYS = 1 << KEY_BITS;
  localparam int HW   = $clog2(HEAP_DEPTH);
  localparam int CW   = $clog2(HEAP_DEPTH + 1);
  localparam int XW   = CW + 1;
  localparam int EW   = 1 + TIME_BITS;
  localparam int PW   = KEY_BITS + TIME_BITS;

  logic [EW-1:0] ent_mem [KEYS];
  logic [PW-1:0] heap_mem [HEAP_DEPTH];

  logic [2:0]           mode_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [TIME_BITS-1:0] dl_r, now_r;
  logic [7:0]           batch_r, swept_r;
  logic [CW-1:0]        count_r;
  logic [HW-1:0]        hole_r;
  logic [KEY_BITS-1:0]  itk_r;
  logic [TIME_BITS-1:0] itd_r;
  logic                 lok_r, rok_r;
  logic [KEY_BITS-1:0]  clr_r;
  logic                 ent_v_q;
  logic [TIME_BITS-1:0] ent_d_q;
  logic [PW-1:0]        ha_q, hb_q;
  logic                 hit_r, exp_r, full_r, valid_r;
  logic [TIME_BITS-1:0] dout_r;

  logic [KEY_BITS-1:0]  ha_k, hb_k;
  logic [TIME_BITS-1:0] ha_d, hb_d;
  logic [XW-1:0]        l_idx, r_idx;
  logic [HW-1:0]        par_idx;
  logic                 add_upd, heap_is_full, expired, sel_l, sel_r;
  logic [KEY_BITS-1:0]  ent_ra, ent_wa;
  logic                 ent_we;
  logic [EW-1:0]        ent_wd;
  logic [HW-1:0]        hra_a, hra_b, hwa;
  logic                 heap_we;
  logic [PW-1:0]        hwd;

  function automatic logic pair_lt(input logic [TIME_BITS-1:0] da,
                                   input logic [KEY_BITS-1:0] ka,
                                   input logic [TIME_BITS-1:0] db,
                                   input logic [KEY_BITS-1:0] kb);
    pair_lt = (da < db) || ((da == db) && (ka < kb));
  endfunction

  assign ha_k = ha_q[PW-1:TIME_BITS];
  assign ha_d = ha_q[TIME_BITS-1:0];
  assign hb_k = hb_q[PW-1:TIME_BITS];
  assign hb_d = hb_q[TIME_BITS-1:0];

  assign l_idx   = {hole_r, 1'b1} + XW'(0);
  assign r_idx   = l_idx + XW'(1);
  assign par_idx = HW'((hole_r - HW'(1)) >> 1);

  assign add_upd      = !ent_v_q || (dl_r < ent_d_q);
  assign heap_is_full = (count_r == CW'(HEAP_DEPTH));
  assign expired      = ent_v_q && (now_r >= ent_d_q);
  assign sel_l        = lok_r && pair_lt(ha_d, ha_k, itd_r, itk_r);
  assign sel_r        = rok_r && (sel_l ? pair_lt(hb_d, hb_k, ha_d, ha_k)
                                        : pair_lt(hb_d, hb_k, itd_r, itk_r));

  always_comb begin
    status.mode       = mode_r;
    status.push       = (mode_r == MODE_ADD) && add_upd && !heap_is_full;
    status.hole_zero  = (hole_r == '0);
    status.item_lt_a  = pair_lt(itd_r, itk_r, ha_d, ha_k);
    status.dn_move    = sel_l || sel_r;
    status.stale      = !ent_v_q || (ent_d_q != ha_d);
    status.due        = (now_r >= ha_d);
    status.sweep_stop = (swept_r >= batch_r) || (count_r == '0);
    status.clr_last   = (clr_r == '1);
  end

  // entry memory ports
  always_comb begin
    ent_ra = (cmd.op == OP_LOAD) ? in_key : ha_k;
    ent_we = 1'b0;
    ent_wa = key_r;
    ent_wd = {1'b0, ent_d_q};
    case (cmd.op)
      OP_EVAL: begin
        case (mode_r)
          MODE_ADD: begin
            ent_we = add_upd;
            ent_wd = {1'b1, dl_r};
          end
          MODE_REMOVE: ent_we = 1'b1;
          MODE_CHECK:  ent_we = expired;
          default:     ent_we = 1'b0;
        endcase
      end
      OP_SW_KILL: begin
        ent_we = 1'b1;
        ent_wa = ha_k;
        ent_wd = {1'b0, ha_d};
      end
      OP_CLR: begin
        ent_we = 1'b1;
        ent_wa = clr_r;
        ent_wd = '0;
      end
      default: ent_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_wa] <= ent_wd;
    end
    {ent_v_q, ent_d_q} <= ent_mem[ent_ra];
  end

  // heap memory ports
  always_comb begin
    hra_a   = '0;
    hra_b   = HW'(r_idx);
    heap_we = 1'b0;
    hwa     = hole_r;
    hwd     = {itk_r, itd_r};
    case (cmd.op)
      OP_UP_RD:   hra_a = par_idx;
      OP_DN_LAST: hra_a = HW'(count_r - CW'(1));
      OP_DN_RD:   hra_a = HW'(l_idx);
      OP_UP_MOVE: begin
        heap_we = 1'b1;
        hwd     = ha_q;
      end
      OP_UP_FIN:  heap_we = 1'b1;
      OP_DN_CMP: begin
        heap_we = 1'b1;
        if (sel_r) begin
          hwd = hb_q;
        end else if (sel_l) begin
          hwd = ha_q;
        end
      end
      default: heap_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (heap_we) begin
      heap_mem[hwa] <= hwd;
    end
    ha_q <= heap_mem[hra_a];
    hb_q <= heap_mem[hra_b];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      clr_r   <= '0;
      batch_r <= BATCH_RESET;
      valid_r <= 1'b0;
    end else begin
      valid_r <= (cmd.op == OP_DONE);
      if (cfg_wr_en) begin
        batch_r <= cfg_wr_data;
      end
      case (cmd.op)
        OP_EVAL: begin
          if ((mode_r == MODE_ADD) && add_upd && !heap_is_full) begin
            count_r <= count_r + CW'(1);
          end
          if (mode_r == MODE_CLEAR) begin
            count_r <= '0;
            clr_r   <= '0;
          end
        end
        OP_DN_LAST: count_r <= count_r - CW'(1);
        OP_CLR:     clr_r   <= clr_r + KEY_BITS'(1);
        default:    count_r <= count_r;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        mode_r  <= in_mode;
        key_r   <= in_key;
        dl_r    <= in_deadline;
        now_r   <= in_now;
        swept_r <= '0;
        hit_r   <= 1'b0;
        exp_r   <= 1'b0;
        full_r  <= 1'b0;
        dout_r  <= '0;
      end
      OP_EVAL: begin
        hit_r <= (mode_r <= MODE_SWEEP) && ent_v_q;
        case (mode_r)
          MODE_ADD: begin
            itk_r  <= key_r;
            itd_r  <= dl_r;
            hole_r <= HW'(count_r);
            full_r <= add_upd && heap_is_full;
          end
          MODE_CHECK:  exp_r  <= expired;
          MODE_LOOKUP: dout_r <= ent_v_q ? ent_d_q : '0;
          default:     exp_r  <= 1'b0;
        endcase
      end
      OP_UP_MOVE: hole_r <= par_idx;
      OP_DN_LD: begin
        itk_r  <= ha_k;
        itd_r  <= ha_d;
        hole_r <= '0;
      end
      OP_DN_RD: begin
        lok_r <= (l_idx < XW'(count_r));
        rok_r <= (r_idx < XW'(count_r));
      end
      OP_DN_CMP: begin
        if (sel_r) begin
          hole_r <= HW'(r_idx);
        end else if (sel_l) begin
          hole_r <= HW'(l_idx);
        end
      end
      OP_SW_KILL: swept_r <= swept_r + 8'd1;
      default:    hole_r  <= hole_r;
    endcase
  end

  assign out_valid        = valid_r;
  assign out_hit          = hit_r;
  assign out_was_expired  = exp_r;
  assign out_deadline_out = dout_r;
  assign out_swept_count  = swept_r;
  assign out_heap_full    = full_r;

endmodule

`default_nettype wire

### rtl/core/keht_ctrl.sv
// ----------------------------------------------------------------------------
// keht_ctrl
// sequencer for lookup, sift-up, sift-down, sweep and clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module keht_ctrl import keht_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  output cmd_t         cmd,
  input  wire status_t status
);

  localparam int SW = 4;
  localparam logic [SW-1:0] S_IDLE    = 4'd0;
  localparam logic [SW-1:0] S_CLR     = 4'd1;
  localparam logic [SW-1:0] S_EVAL    = 4'd2;
  localparam logic [SW-1:0] S_UP_CHK  = 4'd3;
  localparam logic [SW-1:0] S_UP_CMP  = 4'd4;
  localparam logic [SW-1:0] S_DN_LAST = 4'd5;
  localparam logic [SW-1:0] S_DN_LD   = 4'd6;
  localparam logic [SW-1:0] S_DN_RD   = 4'd7;
  localparam logic [SW-1:0] S_DN_CMP  = 4'd8;
  localparam logic [SW-1:0] S_SW_CHK  = 4'd9;
  localparam logic [SW-1:0] S_SW_ENT  = 4'd10;
  localparam logic [SW-1:0] S_SW_EVAL = 4'd11;
  localparam logic [SW-1:0] S_DONE    = 4'd12;

  logic [SW-1:0] state_r, state_nxt;
  logic          by_cmd_r, by_cmd_nxt;

  always_comb begin
    state_nxt  = state_r;
    by_cmd_nxt = by_cmd_r;
    cmd.op     = OP_IDLE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.op = OP_EVAL;
        if (status.push) begin
          state_nxt = S_UP_CHK;
        end else if (status.mode == MODE_CLEAR) begin
          by_cmd_nxt = 1'b1;
          state_nxt  = S_CLR;
        end else if (status.mode == MODE_SWEEP) begin
          state_nxt = S_SW_CHK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CLR: begin
        cmd.op = OP_CLR;
        if (status.clr_last) begin
          state_nxt = by_cmd_r ? S_DONE : S_IDLE;
        end
      end
      S_UP_CHK: begin
        if (status.hole_zero) begin
          cmd.op    = OP_UP_FIN;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_UP_RD;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (status.item_lt_a) begin
          cmd.op    = OP_UP_MOVE;
          state_nxt = S_UP_CHK;
        end else begin
          cmd.op    = OP_UP_FIN;
          state_nxt = S_DONE;
        end
      end
      S_SW_CHK: begin
        if (status.sweep_stop) begin
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_SW_RD;
          state_nxt = S_SW_ENT;
        end
      end
      S_SW_ENT: begin
        cmd.op    = OP_SW_ENT;
        state_nxt = S_SW_EVAL;
      end
      S_SW_EVAL: begin
        if (status.stale) begin
          state_nxt = S_DN_LAST;
        end else if (status.due) begin
          cmd.op    = OP_SW_KILL;
          state_nxt = S_DN_LAST;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DN_LAST: begin
        cmd.op    = OP_DN_LAST;
        state_nxt = S_DN_LD;
      end
      S_DN_LD: begin
        cmd.op    = OP_DN_LD;
        state_nxt = S_DN_RD;
      end
      S_DN_RD: begin
        cmd.op    = OP_DN_RD;
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd.op    = OP_DN_CMP;
        state_nxt = status.dn_move ? S_DN_RD : S_SW_CHK;
      end
      S_DONE: begin
        cmd.op    = OP_DONE;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      by_cmd_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      by_cmd_r <= by_cmd_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

### rtl/core/keht_checker.sv
// ----------------------------------------------------------------------------
// keht_checker
// port-level checks on command transfers and result strobes
// ----------------------------------------------------------------------------
`default_nettype none

`include "key_expiry_heap_table_unit_macros.svh"

module keht_checker #(
  parameter int TIME_BITS = 48
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 out_valid,
  input wire logic                 out_hit,
  input wire logic                 out_was_expired,
  input wire logic [TIME_BITS-1:0] out_deadline_out,
  input wire logic [7:0]           out_swept_count
);

  `KEHT_ASSERT_NXT(a_busy_after_start, start && !busy, busy)
  `KEHT_ASSERT_NXT(a_single_strobe, out_valid, !out_valid)
  `KEHT_ASSERT_IMP(a_expired_needs_hit, out_valid && out_was_expired, out_hit)
  `KEHT_ASSERT_IMP(a_sweep_no_deadline, out_valid && (out_swept_count != 8'd0),
                   (out_deadline_out == '0) && !out_was_expired)

endmodule

bind key_expiry_heap_table_unit keht_checker #(.TIME_BITS(TIME_BITS)) u_keht_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_hit          (out_hit),
  .out_was_expired  (out_was_expired),
  .out_deadline_out (out_deadline_out),
  .out_swept_count  (out_swept_count)
);

`default_nettype wire

### dv/key_expiry_heap_table_checker.sv
// ----------------------------------------------------------------------------
// key_expiry_heap_table_checker
// watches the command, result and register ports of the expiry table, keeps
// its own copy of the table and the lazy-deletion heap, predicts each result
// and compares it field by field with what the block returns
// ----------------------------------------------------------------------------
`default_nettype none

module key_expiry_heap_table_checker import keht_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [2:0]  in_mode,
  input  wire logic [11:0] in_key,
  input  wire logic [47:0] in_deadline,
  input  wire logic [47:0] in_now,
  input  wire logic        out_valid,
  input  wire logic        out_hit,
  input  wire logic        out_was_expired,
  input  wire logic [47:0] out_deadline_out,
  input  wire logic [7:0]  out_swept_count,
  input  wire logic        out_heap_full,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEYS  = 4096;
  localparam int DEPTH = 4096;

  typedef struct packed {
    logic        hit;
    logic        was_expired;
    logic [47:0] deadline_out;
    logic [7:0]  swept_count;
    logic        heap_full;
  } outcome_t;

  bit          live_key [KEYS];
  logic [47:0] key_deadline [KEYS];
  logic [11:0] slot_key [DEPTH];
  logic [47:0] slot_deadline [DEPTH];
  int          slot_count;
  logic [7:0]  batch;
  outcome_t    outcome_q[$];

  function automatic bit slot_lt(int a, int b);
    if (slot_deadline[a] != slot_deadline[b]) return slot_deadline[a] < slot_deadline[b];
    return slot_key[a] < slot_key[b];
  endfunction

  function automatic void slot_exchange(int a, int b);
    logic [11:0] k;
    logic [47:0] d;
    k = slot_key[a];
    d = slot_deadline[a];
    slot_key[a] = slot_key[b];
    slot_deadline[a] = slot_deadline[b];
    slot_key[b] = k;
    slot_deadline[b] = d;
  endfunction

  function automatic bit heap_insert(logic [11:0] k, logic [47:0] d);
    int i;
    int p;
    if (slot_count >= DEPTH) return 1'b0;
    i = slot_count;
    slot_count++;
    slot_key[i] = k;
    slot_deadline[i] = d;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!slot_lt(i, p)) break;
      slot_exchange(i, p);
      i = p;
    end
    return 1'b1;
  endfunction

  function automatic void heap_drop_top();
    int i;
    int l;
    int r;
    int m;
    if (slot_count == 0) return;
    slot_count--;
    slot_key[0] = slot_key[slot_count];
    slot_deadline[0] = slot_deadline[slot_count];
    i = 0;
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      m = i;
      if (l < slot_count && slot_lt(l, m)) m = l;
      if (r < slot_count && slot_lt(r, m)) m = r;
      if (m == i) break;
      slot_exchange(i, m);
      i = m;
    end
  endfunction

  function automatic outcome_t expiry_outcome(logic [2:0] mode, logic [11:0] key,
                                              logic [47:0] dl, logic [47:0] now);
    outcome_t o;
    bit       was_live;
    int       erased;
    logic [11:0] tk;
    logic [47:0] td;
    o = '0;
    was_live = live_key[key];
    if (mode <= MODE_SWEEP) o.hit = was_live;
    case (mode)
      MODE_ADD: begin
        if (!was_live || dl < key_deadline[key]) begin
          live_key[key] = 1'b1;
          key_deadline[key] = dl;
          if (!heap_insert(key, dl)) o.heap_full = 1'b1;
        end
      end
      MODE_REMOVE: live_key[key] = 1'b0;
      MODE_CHECK: begin
        if (was_live && now >= key_deadline[key]) begin
          live_key[key] = 1'b0;
          o.was_expired = 1'b1;
        end
      end
      MODE_LOOKUP: if (was_live) o.deadline_out = key_deadline[key];
      MODE_CLEAR: begin
        live_key = '{default: 1'b0};
        slot_count = 0;
      end
      MODE_SWEEP: begin
        erased = 0;
        while (erased < batch && slot_count > 0) begin
          tk = slot_key[0];
          td = slot_deadline[0];
          if (!live_key[tk] || key_deadline[tk] != td) begin
            heap_drop_top();
          end else if (now >= td) begin
            live_key[tk] = 1'b0;
            heap_drop_top();
            erased++;
          end else begin
            break;
          end
        end
        o.swept_count = erased[7:0];
      end
      default: ;
    endcase
    return o;
  endfunction

  assign pending = outcome_q.size();

  always_ff @(posedge clk) begin
    outcome_t e;
    if (!rst_n) begin
      live_key = '{default: 1'b0};
      slot_count = 0;
      batch = BATCH_RESET;
      outcome_q.delete();
      fail_count <= 0;
    end else begin
      if (out_valid) begin
        if (outcome_q.size() == 0) begin
          $error("result with no transfer outstanding");
          fail_count <= fail_count + 1;
        end else begin
          e = outcome_q.pop_front();
          if (out_hit !== e.hit)
            $error("hit: expected %0d, got %0d", e.hit, out_hit);
          if (out_was_expired !== e.was_expired)
            $error("was_expired: expected %0d, got %0d", e.was_expired, out_was_expired);
          if (out_deadline_out !== e.deadline_out)
            $error("deadline_out: expected %0h, got %0h", e.deadline_out, out_deadline_out);
          if (out_swept_count !== e.swept_count)
            $error("swept_count: expected %0d, got %0d", e.swept_count, out_swept_count);
          if (out_heap_full !== e.heap_full)
            $error("heap_full: expected %0d, got %0d", e.heap_full, out_heap_full);
          if (out_hit !== e.hit || out_was_expired !== e.was_expired ||
              out_deadline_out !== e.deadline_out || out_swept_count !== e.swept_count ||
              out_heap_full !== e.heap_full)
            fail_count <= fail_count + 1;
        end
      end
      if (start && !busy)
        outcome_q.push_back(expiry_outcome(in_mode, in_key, in_deadline, in_now));
      if (cfg_wr_en) batch = cfg_wr_data;
    end
  end

endmodule

`default_nettype wire

### dv/key_expiry_heap_table_unit_tb.sv
// ----------------------------------------------------------------------------
// key_expiry_heap_table_unit_tb
// drives directed and random commands into the expiry table, walks the sweep
// batch size through its extremes and gives the verdict from the checker's
// failure count
// ----------------------------------------------------------------------------
`default_nettype none

module key_expiry_heap_table_unit_tb import keht_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam logic [47:0] T_MAX = 48'hFFFF_FFFF_FFFF;
  localparam int STALL_LIMIT = 250000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_mode = '0;
  logic [11:0] in_key = '0;
  logic [47:0] in_deadline = '0;
  logic [47:0] in_now = '0;
  logic        out_valid;
  logic        out_hit;
  logic        out_was_expired;
  logic [47:0] out_deadline_out;
  logic [7:0]  out_swept_count;
  logic        out_heap_full;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  int          fail_count;
  int          pending;
  int          stall_cycles = 0;
  logic [47:0] clock_now = 48'd1000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  key_expiry_heap_table_unit i_dut (
    .clk, .rst_n, .start, .busy, .in_mode, .in_key, .in_deadline, .in_now,
    .out_valid, .out_hit, .out_was_expired, .out_deadline_out, .out_swept_count,
    .out_heap_full, .cfg_wr_en, .cfg_wr_data
  );

  key_expiry_heap_table_checker i_checker (
    .clk, .rst_n, .start, .busy, .in_mode, .in_key, .in_deadline, .in_now,
    .out_valid, .out_hit, .out_was_expired, .out_deadline_out, .out_swept_count,
    .out_heap_full, .cfg_wr_en, .cfg_wr_data, .fail_count, .pending
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_command(logic [2:0] mode, logic [11:0] key, logic [47:0] dl,
                              logic [47:0] now, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= mode;
    in_key <= key;
    in_deadline <= dl;
    in_now <= now;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
  endtask

  task automatic send_paced(logic [2:0] mode, logic [11:0] key, logic [47:0] dl,
                            logic [47:0] now);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    send_command(mode, key, dl, now, gap);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_batch(logic [7:0] value);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [47:0] wide_random();
    return {$urandom, $urandom};
  endfunction

  task automatic random_command();
    int          pick;
    logic [2:0]  mode;
    logic [11:0] key;
    logic [47:0] dl;
    logic [47:0] now;
    clock_now += $urandom_range(0, 40);
    pick = $urandom_range(0, 199);
    if (pick < 80) mode = MODE_ADD;
    else if (pick < 96) mode = MODE_REMOVE;
    else if (pick < 126) mode = MODE_CHECK;
    else if (pick < 156) mode = MODE_LOOKUP;
    else if (pick < 190) mode = MODE_SWEEP;
    else if (pick < 192) mode = MODE_CLEAR;
    else mode = $urandom_range(0, 1) ? MODE_SPARE_LO : MODE_SPARE_HI;
    key = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 31));
    pick = $urandom_range(0, 19);
    if (pick < 17) dl = clock_now + $urandom_range(0, 300);
    else if (pick < 19) dl = wide_random();
    else dl = $urandom_range(0, 1) ? T_MAX : '0;
    pick = $urandom_range(0, 19);
    if (pick < 17) now = clock_now;
    else if (pick < 19) now = wide_random();
    else now = $urandom_range(0, 1) ? T_MAX : '0;
    send_paced(mode, key, dl, now);
  endtask

  initial begin
    logic [7:0] phase_batch [4];
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every mode and the corner cases
    send_paced(MODE_LOOKUP, 12'd0, '0, '0);
    send_paced(MODE_ADD, 12'd0, '0, '0);
    send_paced(MODE_ADD, 12'hFFF, T_MAX, T_MAX);
    send_paced(MODE_LOOKUP, 12'hFFF, '0, '0);
    send_paced(MODE_ADD, 12'd5, 48'd500, '0);
    send_paced(MODE_ADD, 12'd5, 48'd900, '0);
    send_paced(MODE_ADD, 12'd5, 48'd300, '0);
    send_paced(MODE_LOOKUP, 12'd5, '0, '0);
    send_paced(MODE_CHECK, 12'd5, '0, 48'd299);
    send_paced(MODE_CHECK, 12'd5, '0, 48'd300);
    send_paced(MODE_CHECK, 12'd5, '0, T_MAX);
    send_paced(MODE_REMOVE, 12'd0, '0, '0);
    send_paced(MODE_REMOVE, 12'd0, '0, '0);
    send_paced(MODE_ADD, 12'd7, 48'd10, '0);
    send_paced(MODE_ADD, 12'd6, 48'd10, '0);
    send_paced(MODE_SWEEP, '0, '0, 48'd9);
    send_paced(MODE_SWEEP, '0, '0, T_MAX);
    send_paced(MODE_SPARE_LO, 12'hFFF, T_MAX, T_MAX);
    send_paced(MODE_SPARE_HI, 12'hFFF, T_MAX, T_MAX);
    send_paced(MODE_ADD, 12'd9, 48'd1, '0);
    write_batch(8'd0);
    send_paced(MODE_SWEEP, '0, '0, T_MAX);
    send_paced(MODE_CLEAR, 12'hFFF, T_MAX, T_MAX);
    send_paced(MODE_LOOKUP, 12'hFFF, '0, '0);

    write_batch(8'd3);
    send_paced(MODE_ADD, 12'd4095, 48'd5, '0);
    send_paced(MODE_LOOKUP, 12'd4095, '0, '0);
    send_paced(MODE_SWEEP, '0, '0, T_MAX);
    send_paced(MODE_CHECK, 12'd4, '0, T_MAX);
    send_paced(MODE_CLEAR, '0, '0, '0);

    phase_batch[0] = 8'd255;
    phase_batch[1] = 8'd1;
    phase_batch[2] = 8'($urandom_range(2, 254));
    phase_batch[3] = BATCH_RESET;
    for (int p = 0; p < 4; p++) begin
      write_batch(phase_batch[p]);
      for (int n = 0; n < 400; n++) random_command();
    end

    start <= 1'b0;
    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
+incdir+rtl/core
rtl/core/keht_pkg.sv
rtl/core/keht_datapath.sv
rtl/core/keht_ctrl.sv
rtl/core/key_expiry_heap_table_unit.sv
rtl/core/keht_checker.sv
dv/key_expiry_heap_table_checker.sv
dv/key_expiry_heap_table_unit_tb.sv
